### design/hsl_pkg.sv
`timescale 1ns / 1ps
package hsl_pkg;

  localparam int ChanW = 8;
  localparam int FracW = 16;
  localparam int UnitW = FracW + 1;        // Q1.16, 0..65536
  localparam int QuoW  = 18;               // divider quotient bits, even
  localparam int DivW  = 11;               // divisor bits (6*d up to 1530)
  localparam int NumW  = DivW + QuoW;      // numerator bits
  localparam int DivStg = QuoW / 2;        // two quotient bits per stage
  localparam int CfgW  = 10;

  // divider lanes
  localparam int NDiv   = 2;
  localparam int DivHue = 0;
  localparam int DivSat = 1;

  // constant divisions: floor(x * Recip >> Shift) is exact over the operand range
  localparam logic [26:0] LitRecip = 27'd67372037;   // 1/510
  localparam int          LitShift = 35;
  localparam logic [24:0] HshRecip = 25'd23860930;   // 1/360
  localparam int          HshShift = 33;
  localparam logic [24:0] PctRecip = 25'd21474837;   // 1/100
  localparam int          PctShift = 31;

  localparam logic [UnitW-1:0] OneQ16      = 17'd65536;
  localparam logic [FracW-1:0] ThirdTurn   = 16'd21845;
  localparam logic [FracW-1:0] TwoThirdAdd = 16'd43691;
  localparam logic [FracW-1:0] SixthLimit  = 16'd10923;
  localparam logic [FracW-1:0] HalfTurn    = 16'd32768;
  localparam logic [FracW-1:0] TwoThirdLim = 16'd43691;
  localparam logic [UnitW-1:0] GreyLimit   = 17'd7;

  typedef enum logic [1:0] {
    CFG_HUE   = 2'd0,
    CFG_SAT   = 2'd1,
    CFG_LIGHT = 2'd2,
    CFG_MASK  = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    SEG_RISE,
    SEG_TOP,
    SEG_FALL,
    SEG_BOTTOM
  } seg_t;

  typedef struct packed {
    logic             pass;
    logic             grey;
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic             last;
    logic             sat_neg;
    logic             light_neg;
    logic [UnitW-1:0] lit;
    logic [FracW-1:0] hsh;
    logic [UnitW-1:0] sof;
    logic [UnitW-1:0] lof;
  } side_t;

endpackage

### design/hsl_if.sv
`timescale 1ns / 1ps
interface hsl_in_if import hsl_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ChanW-1:0] red_in;
  logic [ChanW-1:0] green_in;
  logic [ChanW-1:0] blue_in;
  logic             selected;
  logic             last_entry;
  modport source (output valid, red_in, green_in, blue_in, selected, last_entry,
                  input ready);
  modport sink   (input valid, red_in, green_in, blue_in, selected, last_entry,
                  output ready);
endinterface

interface hsl_out_if import hsl_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ChanW-1:0] red_out;
  logic [ChanW-1:0] green_out;
  logic [ChanW-1:0] blue_out;
  logic             last_out;
  modport source (output valid, red_out, green_out, blue_out, last_out, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, last_out, output ready);
endinterface

interface hsl_cfg_if import hsl_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [1:0]      index;
  logic [CfgW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### design/hsl_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider, two quotient bits per stage.
// Requires num < dvs * 2**QW and dvs != 0.
module hsl_div #(
  parameter int NW = 29,
  parameter int DW = 11,
  parameter int QW = 18
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] dvs,
  output logic [QW-1:0] quo
);

  localparam int Stg = QW / 2;

  logic [DW-1:0] rem_r [Stg+1];
  logic [QW-1:0] low_r [Stg+1];
  logic [QW-1:0] quo_r [Stg+1];
  logic [DW-1:0] dvs_r [Stg+1];

  always_comb begin
    rem_r[0] = num[NW-1:QW];
    low_r[0] = num[QW-1:0];
    quo_r[0] = '0;
    dvs_r[0] = dvs;
  end

  for (genvar k = 0; k < Stg; k++) begin : g_stg
    logic [DW:0]   sh0, sh1;
    logic [DW-1:0] r0, r1;
    logic          b0, b1;

    always_comb begin
      sh0 = {rem_r[k], low_r[k][QW-1]};
      b0  = sh0 >= {1'b0, dvs_r[k]};
      r0  = b0 ? DW'(sh0 - {1'b0, dvs_r[k]}) : sh0[DW-1:0];
      sh1 = {r0, low_r[k][QW-2]};
      b1  = sh1 >= {1'b0, dvs_r[k]};
      r1  = b1 ? DW'(sh1 - {1'b0, dvs_r[k]}) : sh1[DW-1:0];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1] <= r1;
        low_r[k+1] <= {low_r[k][QW-3:0], 2'b00};
        quo_r[k+1] <= {quo_r[k][QW-3:0], b0, b1};
        dvs_r[k+1] <= dvs_r[k];
      end
    end
  end

  assign quo = quo_r[Stg];

endmodule

### design/hsl_front.sv
`timescale 1ns / 1ps
// Color analysis: max/min, divider operands for h and s; l and the config
// offsets come from reciprocal multiplies and ride along with the side data.
module hsl_front import hsl_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [ChanW-1:0]       red,
  input  logic [ChanW-1:0]       green,
  input  logic [ChanW-1:0]       blue,
  input  logic                   selected,
  input  logic                   last_entry,
  input  logic signed [9:0]      hue_deg,
  input  logic signed [7:0]      sat_pct,
  input  logic signed [7:0]      lum_pct,
  input  logic                   mask_on,
  output logic                   vld,
  output side_t                  side,
  output logic [NumW-1:0]        num [NDiv],
  output logic [DivW-1:0]        dvs [NDiv]
);

  logic [ChanW-1:0] mx, mn, d;
  logic [8:0]       sum, den;
  logic [DivW-1:0]  hnum;
  logic             grey;
  logic [10:0]      hm0, hm1, hm2;
  logic [7:0]       smag, lmag;
  logic [24:0]      lit_num, hsh_num;
  logic [51:0]      lit_prod;
  logic [49:0]      hsh_prod;
  logic [23:0]      sof_num, lof_num;
  logic [48:0]      sof_prod, lof_prod;

  logic             vld_r;
  side_t            side_r;
  logic [NumW-1:0]  num_r [NDiv];
  logic [DivW-1:0]  dvs_r [NDiv];

  always_comb begin
    mx   = (red > green) ? ((red > blue) ? red : blue) : ((green > blue) ? green : blue);
    mn   = (red < green) ? ((red < blue) ? red : blue) : ((green < blue) ? green : blue);
    sum  = {1'b0, mx} + {1'b0, mn};
    d    = mx - mn;
    grey = (mx == mn);
    den  = (sum > 9'd255) ? 9'(10'd510 - {1'b0, sum}) : sum;
    if (red == mx)
      hnum = DivW'({3'b0, green}) - DivW'({3'b0, blue})
             + ((green < blue) ? DivW'(6 * d) : '0);
    else if (green == mx)
      hnum = DivW'({3'b0, blue}) - DivW'({3'b0, red}) + DivW'({d, 1'b0});
    else
      hnum = DivW'({3'b0, red}) - DivW'({3'b0, green}) + DivW'({d, 2'b00});
    // floor mod 360 of a 10-bit signed value
    hm0 = 11'($signed({hue_deg[9], hue_deg}) + 11'sd720);
    hm1 = (hm0 >= 11'd720) ? 11'(hm0 - 11'd720) : hm0;
    hm2 = (hm1 >= 11'd360) ? 11'(hm1 - 11'd360) : hm1;
    smag = sat_pct[7] ? 8'(-sat_pct) : sat_pct;
    lmag = lum_pct[7] ? 8'(-lum_pct) : lum_pct;
    lit_num  = {sum, 16'b0} + 25'd255;
    lit_prod = 52'(lit_num) * 52'(LitRecip);
    hsh_num  = {hm2[8:0], 16'b0} + 25'd180;
    hsh_prod = 50'(hsh_num) * 50'(HshRecip);
    sof_num  = {smag, 16'b0} + 24'd50;
    sof_prod = 49'(sof_num) * 49'(PctRecip);
    lof_num  = {lmag, 16'b0} + 24'd50;
    lof_prod = 49'(lof_num) * 49'(PctRecip);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r.pass      <= mask_on && !selected;
      side_r.grey      <= grey;
      side_r.red       <= red;
      side_r.green     <= green;
      side_r.blue      <= blue;
      side_r.last      <= last_entry;
      side_r.sat_neg   <= sat_pct[7];
      side_r.light_neg <= lum_pct[7];
      side_r.lit       <= lit_prod[LitShift +: UnitW];
      side_r.hsh       <= hsh_prod[HshShift +: FracW];
      side_r.sof       <= sof_prod[PctShift +: UnitW];
      side_r.lof       <= lof_prod[PctShift +: UnitW];
      num_r[DivHue] <= NumW'({hnum, 16'b0}) + NumW'(3 * d);
      dvs_r[DivHue] <= grey ? DivW'(1) : DivW'(6 * d);
      num_r[DivSat] <= NumW'({d, 16'b0}) + NumW'(den[8:1]);
      dvs_r[DivSat] <= grey ? DivW'(1) : DivW'(den);
    end
  end

  assign vld  = vld_r;
  assign side = side_r;
  assign num  = num_r;
  assign dvs  = dvs_r;

endmodule

### design/hsl_back.sv
`timescale 1ns / 1ps
// Offsets and clamps, HSL to RGB, rounding to 8 bits, output register.
module hsl_back import hsl_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             vld_in,
  input  side_t            side_in,
  input  logic [QuoW-1:0]  quo [NDiv],
  output logic             vld,
  output logic [ChanW-1:0] red_out,
  output logic [ChanW-1:0] green_out,
  output logic [ChanW-1:0] blue_out,
  output logic             last_out
);

  function automatic logic [ChanW-1:0] to_u8(input logic [17:0] v);
    logic [26:0] c;
    begin
      c = (27'(v) * 27'd255 + 27'd32768) >> 16;
      to_u8 = (c > 27'd255) ? 8'd255 : c[7:0];
    end
  endfunction

  function automatic logic [UnitW-1:0] clamp_add(input logic [UnitW-1:0] a,
                                                 input logic [UnitW-1:0] b,
                                                 input logic neg);
    logic signed [18:0] v;
    begin
      v = neg ? $signed({2'b0, a}) - $signed({2'b0, b})
              : $signed({2'b0, a}) + $signed({2'b0, b});
      if (v < 0)
        clamp_add = '0;
      else if (v > $signed({2'b0, OneQ16}))
        clamp_add = OneQ16;
      else
        clamp_add = v[UnitW-1:0];
    end
  endfunction

  logic [4:0] vld_r;
  side_t      sd_r [5];

  // B1
  logic [FracW-1:0] h1_r;
  logic [UnitW-1:0] s1_r, l1_r;
  // B2
  logic [FracW-1:0] h2_r;
  logic [UnitW-1:0] s2_r, l2_r, ls2_r;
  logic             low2_r;
  // B3
  logic [17:0]      p3_r, q3_r;
  logic [FracW-1:0] t3_r [3];
  logic [UnitW-1:0] l3_r;
  logic             low3_r;
  // B4
  logic [17:0]      p4_r [3];
  logic [17:0]      q4_r;
  logic [34:0]      prod4_r [3];
  seg_t             seg4_r [3];
  logic [UnitW-1:0] l4_r;
  logic             low4_r;
  // B5
  logic [ChanW-1:0] r5_r, g5_r, b5_r;

  logic [FracW-1:0] hraw;
  logic [UnitW-1:0] sraw;
  logic [33:0]      lsprod;
  logic [17:0]      qn;
  logic signed [18:0] pi;
  logic [17:0]      pn;
  logic [17:0]      diff;
  logic [34:0]      prod_nxt [3];
  seg_t             seg_nxt [3];
  logic [ChanW-1:0] ch_nxt [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[3:0], vld_in};
    end
  end

  always_comb begin
    hraw   = side_in.grey ? '0 : quo[DivHue][FracW-1:0];
    sraw   = side_in.grey ? '0 : quo[DivSat][UnitW-1:0];
    lsprod = (34'(l1_r) * 34'(s1_r) + 34'd32768) >> 16;
    qn     = (l2_r < {1'b0, HalfTurn}) ? 18'(l2_r) + 18'(ls2_r)
                                      : 18'(l2_r) + 18'(s2_r) - 18'(ls2_r);
    pi     = $signed({1'b0, l2_r, 1'b0}) - $signed({1'b0, qn});
    pn     = (pi < 0) ? '0 : pi[17:0];
    if (pn > qn) pn = qn;
    diff   = q3_r - p3_r;
    for (int c = 0; c < 3; c++) begin
      if (t3_r[c] < SixthLimit) begin
        seg_nxt[c]  = SEG_RISE;
        prod_nxt[c] = 35'(diff) * 35'(19'(t3_r[c]) * 19'd6);
      end else if (t3_r[c] < HalfTurn) begin
        seg_nxt[c]  = SEG_TOP;
        prod_nxt[c] = '0;
      end else if (t3_r[c] < TwoThirdLim) begin
        seg_nxt[c]  = SEG_FALL;
        prod_nxt[c] = 35'(diff) * 35'(19'd262143 - 19'(t3_r[c]) * 19'd6 + 19'd1);
      end else begin
        seg_nxt[c]  = SEG_BOTTOM;
        prod_nxt[c] = '0;
      end
    end
    for (int c = 0; c < 3; c++) begin
      case (seg4_r[c])
        SEG_RISE, SEG_FALL:
          ch_nxt[c] = to_u8(p4_r[c] + 18'((prod4_r[c] + 35'd32768) >> 16));
        SEG_TOP:    ch_nxt[c] = to_u8(q4_r);
        SEG_BOTTOM: ch_nxt[c] = to_u8(p4_r[c]);
        default:    ch_nxt[c] = to_u8(p4_r[c]);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd_r[0] <= side_in;
      for (int k = 1; k < 5; k++) sd_r[k] <= sd_r[k-1];

      h1_r <= hraw + side_in.hsh;
      s1_r <= clamp_add(sraw, side_in.sof, side_in.sat_neg);
      l1_r <= clamp_add(side_in.lit, side_in.lof, side_in.light_neg);

      h2_r   <= h1_r;
      s2_r   <= s1_r;
      l2_r   <= l1_r;
      ls2_r  <= lsprod[UnitW-1:0];
      low2_r <= s1_r < GreyLimit;

      p3_r    <= pn;
      q3_r    <= qn;
      t3_r[0] <= h2_r + ThirdTurn;
      t3_r[1] <= h2_r;
      t3_r[2] <= h2_r + TwoThirdAdd;
      l3_r    <= l2_r;
      low3_r  <= low2_r;

      for (int c = 0; c < 3; c++) begin
        p4_r[c]    <= p3_r;
        prod4_r[c] <= prod_nxt[c];
        seg4_r[c]  <= seg_nxt[c];
      end
      q4_r   <= q3_r;
      l4_r   <= l3_r;
      low4_r <= low3_r;

      if (sd_r[3].pass) begin
        r5_r <= sd_r[3].red;
        g5_r <= sd_r[3].green;
        b5_r <= sd_r[3].blue;
      end else if (low4_r) begin
        r5_r <= to_u8(18'(l4_r));
        g5_r <= to_u8(18'(l4_r));
        b5_r <= to_u8(18'(l4_r));
      end else begin
        r5_r <= ch_nxt[0];
        g5_r <= ch_nxt[1];
        b5_r <= ch_nxt[2];
      end
    end
  end

  assign vld       = vld_r[4];
  assign red_out   = r5_r;
  assign green_out = g5_r;
  assign blue_out  = b5_r;
  assign last_out  = sd_r[4].last;

endmodule

### design/hsl_color_adjust.sv
`timescale 1ns / 1ps
// The pipeline has 1 analysis stage, 9 divider stages at two quotient bits
//   each, and 5 conversion stages.
// Throughput: one color per cycle; the whole pipeline holds while the
//   result register is full and not taken.
// Reset (rst_n low, synchronous) clears all valid bits and the config registers.
module hsl_color_adjust import hsl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  hsl_in_if.sink    in_ch,
  hsl_out_if.source out_ch,
  hsl_cfg_if.sink   cfg_ch
);

  logic signed [9:0] hue_deg_r;
  logic signed [7:0] sat_pct_r, lum_pct_r;
  logic              mask_r;

  logic              en;
  logic              fe_vld, be_vld;
  side_t             fe_side;
  logic [NumW-1:0]   fe_num [NDiv];
  logic [DivW-1:0]   fe_dvs [NDiv];
  logic [QuoW-1:0]   quo [NDiv];
  logic              dvld_r [DivStg];
  side_t             dside_r [DivStg];

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hue_deg_r <= '0;
      sat_pct_r <= '0;
      lum_pct_r <= '0;
      mask_r    <= 1'b0;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_idx_t'(cfg_ch.index))
        CFG_HUE:   hue_deg_r <= cfg_ch.data;
        CFG_SAT:   sat_pct_r <= cfg_ch.data[7:0];
        CFG_LIGHT: lum_pct_r <= cfg_ch.data[7:0];
        CFG_MASK:  mask_r    <= cfg_ch.data[0];
        default:   mask_r    <= mask_r;
      endcase
    end
  end

  assign en          = !be_vld || out_ch.ready;
  assign in_ch.ready = en;

  hsl_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (in_ch.valid),
    .red        (in_ch.red_in),
    .green      (in_ch.green_in),
    .blue       (in_ch.blue_in),
    .selected   (in_ch.selected),
    .last_entry (in_ch.last_entry),
    .hue_deg    (hue_deg_r),
    .sat_pct    (sat_pct_r),
    .lum_pct    (lum_pct_r),
    .mask_on    (mask_r),
    .vld        (fe_vld),
    .side       (fe_side),
    .num        (fe_num),
    .dvs        (fe_dvs)
  );

  for (genvar i = 0; i < NDiv; i++) begin : g_div
    hsl_div #(.NW(NumW), .DW(DivW), .QW(QuoW)) u_div (
      .clk (clk),
      .en  (en),
      .num (fe_num[i]),
      .dvs (fe_dvs[i]),
      .quo (quo[i])
    );
  end

  // side data and valid follow the divider stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DivStg; k++) dvld_r[k] <= 1'b0;
    end else if (en) begin
      dvld_r[0] <= fe_vld;
      for (int k = 1; k < DivStg; k++) dvld_r[k] <= dvld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dside_r[0] <= fe_side;
      for (int k = 1; k < DivStg; k++) dside_r[k] <= dside_r[k-1];
    end
  end

  hsl_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .vld_in    (dvld_r[DivStg-1]),
    .side_in   (dside_r[DivStg-1]),
    .quo       (quo),
    .vld       (be_vld),
    .red_out   (out_ch.red_out),
    .green_out (out_ch.green_out),
    .blue_out  (out_ch.blue_out),
    .last_out  (out_ch.last_out)
  );

  assign out_ch.valid = be_vld;

endmodule

### design/hsl_color_adjust_chk.sv
`timescale 1ns / 1ps
module hsl_color_adjust_chk import hsl_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [ChanW-1:0] red_out,
  input logic [ChanW-1:0] green_out,
  input logic [ChanW-1:0] blue_out,
  input logic             last_out,
  input logic             cfg_ready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(red_out) && $stable(green_out)
                                && $stable(blue_out) && $stable(last_out))
    else $error("stalled result changed");

  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("input ready not tied to output stall");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready)
    else $error("config port not ready");

endmodule

bind hsl_color_adjust hsl_color_adjust_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .red_out   (out_ch.red_out),
  .green_out (out_ch.green_out),
  .blue_out  (out_ch.blue_out),
  .last_out  (out_ch.last_out),
  .cfg_ready (cfg_ch.ready)
);

### tb/sv/hsl_color_adjust_checker.sv
`timescale 1ns / 1ps
module hsl_color_adjust_checker import hsl_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  hsl_in_if.sink  in_mon,
  hsl_out_if.sink out_mon,
  hsl_cfg_if.sink cfg_mon,
  output int     n_fail,
  output int     n_pending,
  output int     n_colors
);

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic             last;
  } color_t;

  color_t expected_colors[$];

  logic signed [9:0] hue_deg;
  logic signed [7:0] sat_pct;
  logic signed [7:0] lum_pct;
  logic              mask_on;

  function automatic longint pct_q16(longint pct);
    longint mag, q;
    mag = pct < 0 ? -pct : pct;
    q = (mag * 65536 + 50) / 100;
    return pct < 0 ? -q : q;
  endfunction

  function automatic longint clamp_unit(longint v);
    if (v < 0) return 0;
    if (v > 65536) return 65536;
    return v;
  endfunction

  function automatic longint mulq(longint a, longint b);
    return (a * b + 32768) >>> 16;
  endfunction

  function automatic longint ramp(longint p, longint q, longint t);
    t = t & 16'hFFFF;
    if (t < 10923) return p + mulq(q - p, 6 * t);
    if (t < 32768) return q;
    if (t < 43691) return p + mulq(q - p, 262144 - 6 * t);
    return p;
  endfunction

  function automatic logic [7:0] to_chan(longint v);
    longint c;
    c = (v * 255 + 32768) >>> 16;
    return c > 255 ? 8'd255 : 8'(c);
  endfunction

  function automatic color_t adjust_color(logic [7:0] r8, logic [7:0] g8, logic [7:0] b8,
                                          logic sel, logic last);
    color_t o;
    longint r, g, b, mx, mn, sum, l, s, h, d, den, num, hd, ls, q, p;
    r = r8; g = g8; b = b8;
    o.last = last;
    if (mask_on && !sel) begin
      o.red = r8; o.green = g8; o.blue = b8;
      return o;
    end
    mx = r > g ? (r > b ? r : b) : (g > b ? g : b);
    mn = r < g ? (r < b ? r : b) : (g < b ? g : b);
    sum = mx + mn;
    l = (sum * 65536 + 255) / 510;
    s = 0;
    h = 0;
    if (mx != mn) begin
      d = mx - mn;
      den = sum > 255 ? 510 - sum : sum;
      s = (d * 65536 + den / 2) / den;
      if (r == mx) num = g - b + (g < b ? 6 * d : 0);
      else if (g == mx) num = b - r + 2 * d;
      else num = r - g + 4 * d;
      // negative num wraps as unsigned 32-bit before the divide
      h = (((num & 32'hFFFFFFFF) * 65536 & 32'hFFFFFFFF) + 3 * d) / (6 * d);
      h = h & 16'hFFFF;
    end
    hd = longint'(hue_deg) % 360;
    if (hd < 0) hd += 360;
    h = (h + (hd * 65536 + 180) / 360) & 16'hFFFF;
    s = clamp_unit(s + pct_q16(sat_pct));
    l = clamp_unit(l + pct_q16(lum_pct));
    if (s < 7) begin
      o.red = to_chan(l); o.green = o.red; o.blue = o.red;
    end else begin
      ls = mulq(l, s);
      q = l < 32768 ? l + ls : l + s - ls;
      p = 2 * l - q;
      if (p < 0) p = 0;
      if (p > q) p = q;
      o.red   = to_chan(ramp(p, q, h + 21845));
      o.green = to_chan(ramp(p, q, h));
      o.blue  = to_chan(ramp(p, q, h + 65536 - 21845));
    end
    return o;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    n_fail++;
  endtask

  always @(posedge clk) begin
    color_t want;
    if (!rst_n) begin
      hue_deg <= '0; sat_pct <= '0; lum_pct <= '0; mask_on <= 1'b0;
      expected_colors.delete();
      n_fail = 0;
      n_colors <= 0;
      n_pending <= 0;
    end else begin
      if (in_mon.valid && in_mon.ready)
        expected_colors.push_back(adjust_color(in_mon.red_in, in_mon.green_in,
            in_mon.blue_in, in_mon.selected, in_mon.last_entry));
      if (out_mon.valid && out_mon.ready) begin
        n_colors <= n_colors + 1;
        if (expected_colors.size() == 0) begin
          report_mismatch("unexpected transaction", 1, 0);
        end else begin
          want = expected_colors.pop_front();
          if (out_mon.red_out !== want.red)
            report_mismatch("red", out_mon.red_out, want.red);
          if (out_mon.green_out !== want.green)
            report_mismatch("green", out_mon.green_out, want.green);
          if (out_mon.blue_out !== want.blue)
            report_mismatch("blue", out_mon.blue_out, want.blue);
          if (out_mon.last_out !== want.last)
            report_mismatch("last", out_mon.last_out, want.last);
        end
      end
      n_pending <= expected_colors.size();
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_idx_t'(cfg_mon.index))
          CFG_HUE:   hue_deg <= cfg_mon.data;
          CFG_SAT:   sat_pct <= cfg_mon.data[7:0];
          CFG_LIGHT: lum_pct <= cfg_mon.data[7:0];
          CFG_MASK:  mask_on <= cfg_mon.data[0];
          default: ;
        endcase
      end
    end
  end

endmodule

### tb/sv/tb_hsl_color_adjust.sv
`timescale 1ns / 1ps
module tb_hsl_color_adjust;
  import hsl_pkg::*;

  localparam int Latency = 15;
  localparam int CycleLimit = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   n_fail, n_pending, n_colors;
  int   cycles = 0;
  bit   stall_long = 1'b0;
  bit   rand_stall = 1'b1;
  int   n_sent = 0;

  hsl_in_if  in_ch();
  hsl_out_if out_ch();
  hsl_cfg_if cfg_ch();

  hsl_color_adjust u_dut (.clk, .rst_n, .in_ch(in_ch.sink), .out_ch(out_ch.source),
                          .cfg_ch(cfg_ch.sink));

  hsl_color_adjust_checker u_chk (.clk, .rst_n, .in_mon(in_ch.sink),
      .out_mon(out_ch.sink), .cfg_mon(cfg_ch.sink), .n_fail, .n_pending, .n_colors);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("hsl_color_adjust verification failed");
      $finish;
    end
  end

  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 55) return 0;
    if (k < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // receiver: random back-pressure, long hold-off on request
  initial begin
    int n;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_long) begin
        out_ch.ready = 1'b0;
        for (n = 0; n < 60; n++) @(negedge clk);
        stall_long = 1'b0;
        out_ch.ready = 1'b1;
      end else if (rand_stall) begin
        n = gap_len();
        if (n > 0) begin
          out_ch.ready = 1'b0;
          repeat (n - 1) @(negedge clk);
        end else begin
          out_ch.ready = 1'b1;
        end
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  task automatic send_color(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic sel,
                            logic last, bit gaps);
    int n;
    if (gaps) begin
      n = gap_len();
      if (n > 0) begin
        in_ch.valid = 1'b0;
        repeat (n) @(negedge clk);
      end
    end
    in_ch.valid = 1'b1;
    in_ch.red_in = r; in_ch.green_in = g; in_ch.blue_in = b;
    in_ch.selected = sel; in_ch.last_entry = last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    n_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid = 1'b0;
    while (n_pending != 0) @(negedge clk);
    repeat (Latency + 5) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CfgW-1:0] val);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data = val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic set_regs(int hue, int sat, int light, bit mask);
    write_reg(CFG_HUE, CfgW'(hue));
    write_reg(CFG_SAT, CfgW'(sat));
    write_reg(CFG_LIGHT, CfgW'(light));
    write_reg(CFG_MASK, CfgW'(mask));
  endtask

  task automatic random_colors(int count, bit gaps);
    int k;
    logic [7:0] r, g, b, v;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(0, 9);
      r = 8'($urandom); g = 8'($urandom); b = 8'($urandom);
      v = 8'($urandom);
      if (k == 0) begin
        r = v; g = v; b = v;          // grey
      end else if (k == 1) begin
        g = r;                        // tie on two channels
      end else if (k == 2) begin
        r = $urandom_range(0, 1) ? 8'd255 : 8'd0;
      end
      send_color(r, g, b, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), gaps);
    end
    in_ch.valid = 1'b0;
  endtask

  int hue_set[7] = '{0, 360, -360, 511, -512, 120, -45};
  int pct_set[7] = '{0, 100, -100, 127, -128, 37, -63};

  initial begin
    in_ch.valid = 1'b0;
    in_ch.red_in = '0; in_ch.green_in = '0; in_ch.blue_in = '0;
    in_ch.selected = 1'b0; in_ch.last_entry = 1'b0;
    cfg_ch.valid = 1'b0; cfg_ch.index = CFG_HUE; cfg_ch.data = '0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: extremes, greys, ties, pass-through
    send_color(8'd0, 8'd0, 8'd0, 1'b1, 1'b0, 0);
    send_color(8'd255, 8'd255, 8'd255, 1'b0, 1'b1, 0);
    send_color(8'd128, 8'd128, 8'd128, 1'b1, 1'b0, 0);
    send_color(8'd255, 8'd0, 8'd0, 1'b1, 1'b0, 0);
    send_color(8'd0, 8'd255, 8'd0, 1'b1, 1'b0, 0);
    send_color(8'd0, 8'd0, 8'd255, 1'b1, 1'b0, 0);
    send_color(8'd255, 8'd255, 8'd0, 1'b1, 1'b0, 0);
    send_color(8'd0, 8'd255, 8'd255, 1'b1, 1'b0, 0);
    send_color(8'd255, 8'd0, 8'd255, 1'b1, 1'b0, 0);
    send_color(8'd200, 8'd10, 8'd90, 1'b1, 1'b1, 0);
    send_color(8'd1, 8'd0, 8'd0, 1'b1, 1'b0, 0);
    send_color(8'd255, 8'd254, 8'd254, 1'b1, 1'b0, 0);
    send_color(8'd170, 8'd85, 8'd85, 1'b0, 1'b1, 0);
    drain();
    set_regs(0, -100, 0, 1'b1);                 // near-grey result, masking on
    send_color(8'd200, 8'd10, 8'd90, 1'b1, 1'b0, 0);
    send_color(8'd200, 8'd10, 8'd90, 1'b0, 1'b1, 0);
    send_color(8'd85, 8'd170, 8'd170, 1'b0, 1'b0, 0);
    send_color(8'd30, 8'd60, 8'd240, 1'b1, 1'b1, 0);
    drain();

    // random phases across register settings
    for (int ph = 0; ph < 14; ph++) begin
      set_regs(hue_set[ph % 7], pct_set[$urandom_range(0, 6)],
               pct_set[$urandom_range(0, 6)], 1'($urandom_range(0, 1)));
      rand_stall = (ph % 5 != 4);
      if (ph == 3) stall_long = 1'b1;          // fill the pipeline
      random_colors(75, ph != 3);
      drain();
    end
    set_regs($urandom_range(0, 1023) - 512, $urandom_range(0, 255) - 128,
             $urandom_range(0, 255) - 128, 1'b0);
    random_colors(40, 1);
    drain();

    $display("sent %0d colors and checked %0d results over 17 register settings",
             n_sent, n_colors);
    if (n_fail == 0) begin
      $display("hsl_color_adjust verification clean");
    end else begin
      $display("hsl_color_adjust verification failed");
    end
    $finish;
  end

endmodule
